// ===== hdl/dcvlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCT coefficient VLC encoder package
// Shared widths, coding-mode type, queue entry type and the prefix-code ROMs.
// ----------------------------------------------------------------------------
package dcvlc_pkg;

	localparam int COEF_W      = 12;
	localparam int CFG_W       = 12;
	localparam int COUNT_BITS  = 12;
	localparam int CMP_W       = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 20;
	localparam int LEN_W       = 5;
	localparam int CAT_W       = 4;
	localparam int MAG_W       = 11;
	localparam int RUN_W       = 6;
	localparam int ACC_W       = CODE_W + BYTE_W;
	localparam int CNT_W       = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MAG_W-1:0] AC_LIMIT   = 11'd1023;
	localparam logic [MAG_W-1:0] COEF_LIMIT = 11'd2047;
	localparam logic [RUN_W-1:0] RUN_LIMIT  = 6'd63;

	typedef enum logic [1:0] {
		MODE_LUMA_DC   = 2'd0,
		MODE_CHROMA_DC = 2'd1,
		MODE_AC        = 2'd2
	} mode_t;

	typedef struct packed {
		logic [9:0] code;
		logic [3:0] len;
	} vlc_t;

	// One coded item: bits in transmission order (bit 0 leaves first).
	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
		logic              eos;
	} code_entry_t;

	function automatic vlc_t luma_rom(input logic [CAT_W-1:0] cat);
		vlc_t r;
		case (cat)
			4'd1:    r = '{10'd5,   4'd3};
			4'd2:    r = '{10'd3,   4'd3};
			4'd3:    r = '{10'd2,   4'd3};
			4'd4:    r = '{10'd0,   4'd3};
			4'd5:    r = '{10'd1,   4'd3};
			4'd6:    r = '{10'd4,   4'd3};
			4'd7:    r = '{10'd14,  4'd4};
			4'd8:    r = '{10'd30,  4'd5};
			4'd9:    r = '{10'd62,  4'd6};
			4'd10:   r = '{10'd126, 4'd7};
			4'd11:   r = '{10'd127, 4'd7};
			default: r = '{10'd0,   4'd0};
		endcase
		return r;
	endfunction

	function automatic vlc_t chroma_rom(input logic [CAT_W-1:0] cat);
		vlc_t r;
		case (cat)
			4'd1:    r = '{10'd0,   4'd2};
			4'd2:    r = '{10'd4,   4'd3};
			4'd3:    r = '{10'd5,   4'd3};
			4'd4:    r = '{10'd12,  4'd4};
			4'd5:    r = '{10'd13,  4'd4};
			4'd6:    r = '{10'd14,  4'd4};
			4'd7:    r = '{10'd30,  4'd5};
			4'd8:    r = '{10'd62,  4'd6};
			4'd9:    r = '{10'd126, 4'd7};
			4'd10:   r = '{10'd254, 4'd8};
			4'd11:   r = '{10'd255, 4'd8};
			default: r = '{10'd0,   4'd0};
		endcase
		return r;
	endfunction

	function automatic vlc_t ac_rom(input logic [CAT_W-1:0] cat);
		vlc_t r;
		case (cat)
			4'd1:    r = '{10'd1,    4'd2};
			4'd2:    r = '{10'd2,    4'd2};
			4'd3:    r = '{10'd14,   4'd4};
			4'd4:    r = '{10'd30,   4'd5};
			4'd5:    r = '{10'd62,   4'd6};
			4'd6:    r = '{10'd126,  4'd7};
			4'd7:    r = '{10'd254,  4'd8};
			4'd8:    r = '{10'd510,  4'd9};
			4'd9:    r = '{10'd1022, 4'd10};
			4'd10:   r = '{10'd1023, 4'd10};
			default: r = '{10'd0,    4'd0};
		endcase
		return r;
	endfunction

	function automatic vlc_t run_rom(input logic [2:0] idx);
		vlc_t r;
		case (idx)
			3'd0:    r = '{10'd0,  4'd1};
			3'd1:    r = '{10'd2,  4'd2};
			3'd2:    r = '{10'd6,  4'd3};
			3'd3:    r = '{10'd14, 4'd4};
			3'd4:    r = '{10'd30, 4'd5};
			3'd5:    r = '{10'd31, 4'd5};
			default: r = '{10'd0,  4'd0};
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/dcvlc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCT coefficient VLC encoder channels
// Valid/ready channels for coefficient beats in and code byte beats out.
// ----------------------------------------------------------------------------
interface dcvlc_coef_if;
	import dcvlc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [COEF_W-1:0] coefficient;
	logic                     end_of_stream;

	modport source(output valid, output coefficient, output end_of_stream, input ready);
	modport sink(input valid, input coefficient, input end_of_stream, output ready);
endinterface

interface dcvlc_byte_if;
	import dcvlc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;

	modport source(output valid, output out_byte, output last_byte, input ready);
	modport sink(input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== hdl/dcvlc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCT coefficient VLC encoder front end
// Accepts coefficient beats, tracks coding mode and block count, and turns
// each item into one bit string in transmission order for the queue.
// ----------------------------------------------------------------------------
module dcvlc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [dcvlc_pkg::CFG_W-1:0] cfg_wr_data,
	dcvlc_coef_if.sink                 coef,
	input  logic                       q_full,
	output logic                       q_push,
	output dcvlc_pkg::code_entry_t     q_entry
);
	import dcvlc_pkg::*;

	logic [CFG_W-1:0]      luma_dc_blocks_q;
	mode_t                 mode_q;
	logic                  prev_zero_q;
	logic [COUNT_BITS-1:0] dc_count_q;

	logic                  accept;
	logic                  is_ac;
	logic                  run_item;
	logic                  ac_zero;
	logic                  neg;
	logic [COEF_W-1:0]     abs_v;
	logic [MAG_W-1:0]      mag;
	logic [MAG_W-1:0]      signed_bits;
	logic [COEF_W-1:0]     mask;
	logic [CAT_W-1:0]      cat;
	vlc_t                  pfx;
	logic [RUN_W-1:0]      run;
	logic [2:0]            run_cat;
	vlc_t                  run_pfx;
	logic [RUN_W-1:0]      run_off;
	logic [CODE_W-1:0]     total;
	logic [LEN_W-1:0]      total_len;
	logic [CODE_W-1:0]     aligned;
	logic [CODE_W-1:0]     rev;
	logic                  eob;
	logic                  count_hit;

	assign accept   = coef.valid && coef.ready;
	assign is_ac    = (mode_q == MODE_AC);
	assign run_item = is_ac && prev_zero_q;
	assign ac_zero  = is_ac && !prev_zero_q && (coef.coefficient == '0);
	assign neg      = coef.coefficient[COEF_W-1];

	// Magnitude and size category of a plain coefficient.
	always_comb begin
		abs_v = neg ? COEF_W'(-coef.coefficient) : COEF_W'(coef.coefficient);
		if (is_ac && (abs_v > COEF_W'(AC_LIMIT))) begin
			mag = AC_LIMIT;
		end else if (abs_v > COEF_W'(COEF_LIMIT)) begin
			mag = COEF_LIMIT;
		end else begin
			mag = abs_v[MAG_W-1:0];
		end
		cat = CAT_W'(1);
		for (int b = 1; b < MAG_W; b++) begin
			if (mag[b]) begin
				cat = CAT_W'(b + 1);
			end
		end
		mask        = (COEF_W'(1) << cat) - COEF_W'(1);
		signed_bits = (neg ? ~mag : mag) & mask[MAG_W-1:0];
		case (mode_q)
			MODE_LUMA_DC:   pfx = luma_rom(cat);
			MODE_CHROMA_DC: pfx = chroma_rom(cat);
			default:        pfx = ac_rom(cat);
		endcase
	end

	// Zero-run length: clamp, then prefix and offset.
	always_comb begin
		if (neg) begin
			run = '0;
		end else if (coef.coefficient > COEF_W'(RUN_LIMIT)) begin
			run = RUN_LIMIT;
		end else begin
			run = coef.coefficient[RUN_W-1:0];
		end
		if (run[5]) begin
			run_cat = 3'd5;
		end else if (run[4]) begin
			run_cat = 3'd4;
		end else if (run[3]) begin
			run_cat = 3'd3;
		end else if (run[2]) begin
			run_cat = 3'd2;
		end else begin
			run_cat = 3'd1;
		end
		run_pfx = run_rom(run_cat);
		run_off = run & ((RUN_W'(1) << run_cat) - RUN_W'(1));
	end

	assign eob       = run_item && (run == '0);
	assign count_hit = (CMP_W'(dc_count_q) == CMP_W'(luma_dc_blocks_q));

	// Whole code of the item, first bit at the top of its length.
	always_comb begin
		if (run_item) begin
			if (run == '0) begin
				total     = CODE_W'(6);
				total_len = LEN_W'(3);
			end else if (run == RUN_W'(1)) begin
				total     = '0;
				total_len = LEN_W'(3);
			end else begin
				total     = (CODE_W'(run_pfx.code) << run_cat) | CODE_W'(run_off);
				total_len = LEN_W'(2) + LEN_W'(run_pfx.len) + LEN_W'(run_cat);
			end
		end else if (ac_zero) begin
			total     = '0;
			total_len = '0;
		end else begin
			total     = (CODE_W'(pfx.code) << cat) | CODE_W'(signed_bits);
			total_len = LEN_W'(pfx.len) + LEN_W'(cat);
		end
		aligned = total << (LEN_W'(CODE_W) - total_len);
		for (int k = 0; k < CODE_W; k++) begin
			rev[k] = aligned[CODE_W-1-k];
		end
	end

	assign coef.ready    = !q_full;
	assign q_push        = accept && ((total_len != '0) || coef.end_of_stream);
	assign q_entry.bits  = rev;
	assign q_entry.len   = total_len;
	assign q_entry.eos   = coef.end_of_stream;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_dc_blocks_q <= '0;
		end else if (cfg_wr_en) begin
			luma_dc_blocks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_LUMA_DC;
			prev_zero_q <= 1'b0;
			dc_count_q  <= '0;
		end else if (accept) begin
			if (coef.end_of_stream) begin
				mode_q      <= MODE_LUMA_DC;
				prev_zero_q <= 1'b0;
				dc_count_q  <= '0;
			end else if (run_item) begin
				prev_zero_q <= 1'b0;
				if (eob) begin
					if (count_hit) begin
						mode_q <= MODE_CHROMA_DC;
					end else begin
						mode_q     <= MODE_LUMA_DC;
						dc_count_q <= dc_count_q + COUNT_BITS'(1);
					end
				end
			end else if (ac_zero) begin
				prev_zero_q <= 1'b1;
			end else begin
				prev_zero_q <= (coef.coefficient == '0);
				mode_q      <= MODE_AC;
			end
		end
	end

endmodule

// ===== hdl/dcvlc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCT coefficient VLC encoder code queue
// Small first-in first-out queue of coded items between front and back end.
// ----------------------------------------------------------------------------
module dcvlc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dcvlc_pkg::code_entry_t push_entry,
	input  logic                   pop,
	output dcvlc_pkg::code_entry_t head,
	output logic                   full,
	output logic                   empty
);
	import dcvlc_pkg::*;

	code_entry_t       slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/dcvlc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCT coefficient VLC encoder back end
// Packs queued bit strings LSB-first into bytes, flushes and marks the last
// byte at end of stream, and holds each byte in an output register.
// ----------------------------------------------------------------------------
module dcvlc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dcvlc_pkg::code_entry_t head,
	input  logic                   q_empty,
	output logic                   q_pop,
	dcvlc_byte_if.source           code
);
	import dcvlc_pkg::*;

	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              eos_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              out_free;
	logic              need_emit;
	logic              emit;
	logic [CNT_W-1:0]  emit_cnt;
	logic [CNT_W-1:0]  load_cnt;

	assign out_free  = !out_valid_q || code.ready;
	// eos_q is only held while bits remain, so it always asks for a byte.
	assign need_emit = (cnt_q >= CNT_W'(BYTE_W)) || eos_q;
	assign emit      = out_free && need_emit;
	assign q_pop     = !need_emit && !q_empty;
	assign emit_cnt  = (cnt_q >= CNT_W'(BYTE_W)) ? cnt_q - CNT_W'(BYTE_W) : '0;
	assign load_cnt  = cnt_q + CNT_W'(head.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			eos_q <= 1'b0;
		end else if (emit) begin
			acc_q <= acc_q >> BYTE_W;
			cnt_q <= emit_cnt;
			eos_q <= eos_q && (emit_cnt != '0);
		end else if (q_pop) begin
			acc_q <= acc_q | (ACC_W'(head.bits) << cnt_q);
			cnt_q <= load_cnt;
			eos_q <= head.eos && (load_cnt != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= acc_q[BYTE_W-1:0];
			out_last_q <= eos_q && (emit_cnt == '0);
		end
	end

	assign code.valid     = out_valid_q;
	assign code.out_byte  = out_byte_q;
	assign code.last_byte = out_last_q;

endmodule

// ===== hdl/dct_coefficient_vlc_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCT coefficient VLC encoder
// Codes signed DCT coefficients and zero runs with fixed prefix codes and
// packs the bit stream LSB-first into bytes.
//
//   Port          Dir  Beat payload
//   coef          in   coefficient (12 bit signed), end_of_stream
//   code          out  out_byte (8 bit), last_byte
//   cfg_wr_en     in   write strobe for luma_dc_blocks
//   cfg_wr_data   in   luma_dc_blocks (12 bit)
//
// The front end takes a coefficient every cycle while the 4-entry code queue
// has room. The packer loads a queued code only when no whole byte or flush is
// pending, then releases each whole byte, flush included, before the next load.
// A zero AC coefficient queues nothing unless it ends the stream, and so leaves
// the packer idle. arst_n clears all mode, count and packing state; the output
// register lets the packer run ahead by one byte while the sink stalls.
// ----------------------------------------------------------------------------
module dct_coefficient_vlc_encoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dcvlc_pkg::CFG_W-1:0] cfg_wr_data,
	dcvlc_coef_if.sink                  coef,
	dcvlc_byte_if.source                code
);
	import dcvlc_pkg::*;

	code_entry_t push_entry;
	code_entry_t head;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;

	dcvlc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.coef        (coef),
		.q_full      (full),
		.q_push      (push),
		.q_entry     (push_entry)
	);

	dcvlc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	dcvlc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (empty),
		.q_pop   (pop),
		.code    (code)
	);

endmodule
